FILE: hw/rtl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared types and constants for the utf-8 validating decoder
// ----------------------------------------------------------------------------
`default_nettype none

package utf8d_pkg;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DECODE_MODE = 1'b0
  } reg_idx_t;

  // decode modes; the unused code behaves as surrogate pass-through
  typedef enum logic [1:0] {
    MODE_STRICT = 2'd0,
    MODE_CESU   = 2'd1,
    MODE_SURR   = 2'd2,
    MODE_SPARE  = 2'd3
  } mode_t;

  // byte classes and code point limits
  localparam logic [7:0]  NUL_LEAD      = 8'hc0;
  localparam logic [7:0]  CONT_NUL      = 8'h80;
  localparam logic [7:0]  LEAD2_LO      = 8'hc2;
  localparam logic [7:0]  LEAD2_HI      = 8'hdf;
  localparam logic [7:0]  LEAD3_LO      = 8'he0;
  localparam logic [7:0]  LEAD3_HI      = 8'hef;
  localparam logic [7:0]  LEAD4_LO      = 8'hf0;
  localparam logic [7:0]  LEAD4_HI      = 8'hf4;
  localparam logic [20:0] CP_MAX        = 21'h10ffff;
  localparam logic [20:0] MIN_2BYTE     = 21'h000080;
  localparam logic [20:0] MIN_3BYTE     = 21'h000800;
  localparam logic [20:0] MIN_4BYTE     = 21'h010000;
  localparam logic [20:0] SURR_HI_LO    = 21'h00d800;
  localparam logic [20:0] SURR_HI_HI    = 21'h00dbff;
  localparam logic [20:0] SURR_LO_LO    = 21'h00dc00;
  localparam logic [20:0] SURR_LO_HI    = 21'h00dfff;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [20:0] code_point;
    logic        point_valid;
    logic        decode_error;
    logic        out_last;
  } out_item_t;

  // per-string decode state
  typedef struct packed {
    logic [1:0]  bytes_rem;
    logic [1:0]  seq_len;
    logic [20:0] acc;
    logic [9:0]  high_surr;
    logic        high_held;
    logic        nul_pend;
    logic        err_seen;
  } dec_state_t;

endpackage : utf8d_pkg

`default_nettype wire

FILE: hw/rtl/utf8d_cfg.sv
// ----------------------------------------------------------------------------
// utf8d_cfg
// apb-style register block holding the decode mode
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [utf8d_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [utf8d_pkg::CFG_DW-1:0]  pwdata,
  output logic      [utf8d_pkg::CFG_DW-1:0]  prdata,
  output logic                               pready,
  output utf8d_pkg::mode_t                   mode
);
  import utf8d_pkg::*;

  mode_t    mode_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (idx == REG_DECODE_MODE);
  assign mode   = mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STRICT;
    end else if (wr_en) begin
      mode_r <= mode_t'(pwdata[1:0]);
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DECODE_MODE: prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      default:         prdata = '0;
    endcase
  end

endmodule : utf8d_cfg

`default_nettype wire

FILE: hw/rtl/utf8d_decode.sv
// ----------------------------------------------------------------------------
// utf8d_decode
// per-byte decode step and the per-string state register
// ----------------------------------------------------------------------------
`default_nettype none

module utf8d_decode (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire utf8d_pkg::mode_t     mode,
  input  wire utf8d_pkg::in_item_t  item,
  output utf8d_pkg::out_item_t      res
);
  import utf8d_pkg::*;

  dec_state_t  st_r;
  dec_state_t  st_nxt;
  logic [7:0]  b;
  logic [20:0] got;
  logic [20:0] acc_sh;
  logic        done;
  logic        err;
  logic        valid;
  logic [20:0] cp;

  assign b      = item.in_byte;
  assign acc_sh = {st_r.acc[14:0], b[5:0]};

  always_comb begin
    st_nxt = st_r;
    got    = '0;
    done   = 1'b0;
    err    = st_r.err_seen;
    valid  = 1'b0;
    cp     = '0;

    if (!st_r.err_seen) begin
      if (st_r.nul_pend) begin
        st_nxt.nul_pend = 1'b0;
        if (b == CONT_NUL) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end else if (st_r.bytes_rem != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          st_nxt.acc       = acc_sh;
          st_nxt.bytes_rem = st_r.bytes_rem - 2'd1;
          if (st_r.bytes_rem == 2'd1) begin
            if ((acc_sh > CP_MAX) ||
                (st_r.seq_len == 2'd1 && acc_sh < MIN_2BYTE) ||
                (st_r.seq_len == 2'd2 && acc_sh < MIN_3BYTE) ||
                (st_r.seq_len == 2'd3 && acc_sh < MIN_4BYTE)) begin
              err = 1'b1;
            end else begin
              got  = acc_sh;
              done = 1'b1;
            end
          end
        end
      end else if (!b[7]) begin
        got  = {13'd0, b};
        done = 1'b1;
      end else if (mode == MODE_CESU && b == NUL_LEAD) begin
        st_nxt.nul_pend = 1'b1;
      end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
        st_nxt.bytes_rem = 2'd1;
        st_nxt.seq_len   = 2'd1;
        st_nxt.acc       = {16'd0, b[4:0]};
      end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
        st_nxt.bytes_rem = 2'd2;
        st_nxt.seq_len   = 2'd2;
        st_nxt.acc       = {17'd0, b[3:0]};
      end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
        st_nxt.bytes_rem = 2'd3;
        st_nxt.seq_len   = 2'd3;
        st_nxt.acc       = {18'd0, b[2:0]};
      end else begin
        err = 1'b1;
      end

      if (done && !err) begin
        if (st_r.high_held) begin
          if (got inside {[SURR_LO_LO:SURR_LO_HI]}) begin
            // join the held high half with this low half
            cp = SUPP_BASE + {1'b0, st_r.high_surr, got[9:0]};
            valid = 1'b1;
            st_nxt.high_held = 1'b0;
          end else begin
            err = 1'b1;
          end
        end else if (mode == MODE_STRICT && got inside {[SURR_HI_LO:SURR_LO_HI]}) begin
          err = 1'b1;
        end else if (mode == MODE_CESU && got inside {[SURR_HI_LO:SURR_LO_HI]}) begin
          if (got <= SURR_HI_HI) begin
            st_nxt.high_surr = got[9:0];
            st_nxt.high_held = 1'b1;
          end else begin
            err = 1'b1;
          end
        end else begin
          cp    = got;
          valid = 1'b1;
        end
      end

      if (item.in_last &&
          (st_nxt.bytes_rem != 2'd0 || st_nxt.nul_pend || st_nxt.high_held)) begin
        err = 1'b1;
      end
    end

    if (err) begin
      valid           = 1'b0;
      cp              = '0;
      st_nxt.err_seen = 1'b1;
    end

    if (item.in_last) begin
      st_nxt = '0;
    end

    res.code_point   = cp;
    res.point_valid  = valid;
    res.decode_error = err;
    res.out_last     = item.in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

endmodule : utf8d_decode

`default_nettype wire

FILE: hw/rtl/utf8_validating_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder_top
// byte-serial utf-8 decoder with validation and cesu-8 / nul variants
// ----------------------------------------------------------------------------
// One byte per transfer goes in, one result per byte comes out. A result
// carries a code point when that byte finishes one, a sticky error flag that
// stays set from the faulty byte to the end of the string, and a copy of the
// last-byte flag; the consumer should drop a string whose final result shows
// an error. The block sustains one byte per clock while the output side is
// not stalled: a transfer is taken into the input register, decoded there
// against the per-string state, and lands in the output register once that
// register is free; the result is then offered and is transferred when the
// output side is not stalled. The per-string state loop (decode logic and
// state register) holds no further register, which is what allows a new
// byte every clock. The decode mode lives in a register at byte address 0
// and is meant to change only between strings while the block is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validating_decoder_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input byte stream
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire utf8d_pkg::in_item_t           in_data,
  // decoded results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output utf8d_pkg::out_item_t               out_data,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [utf8d_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [utf8d_pkg::CFG_DW-1:0]  pwdata,
  output logic      [utf8d_pkg::CFG_DW-1:0]  prdata,
  output logic                               pready
);
  import utf8d_pkg::*;

  mode_t     mode;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t res;
  logic      out_adv;
  logic      step;

  // output register frees up when empty or when its transfer completes
  assign out_adv  = !out_valid_r || out_ready;
  // decode happens when a byte sits in the input register and can move on
  assign step     = in_valid_r && out_adv;
  // input register takes a byte whenever it is empty or drains this cycle
  assign in_ready = !in_valid_r || out_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  utf8d_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  utf8d_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .mode  (mode),
    .item  (in_item_r),
    .res   (res)
  );

  // input register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // input register: payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_data;
    end
  end

  // output register: control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (step) begin
      out_item_r <= res;
    end
  end

endmodule : utf8_validating_decoder_top

`default_nettype wire

FILE: tb/utf8_validating_decoder_top_test.sv
// ----------------------------------------------------------------------------
// utf8_validating_decoder_top_test
// self-checking regression for the byte-serial utf-8 validating decoder
// ----------------------------------------------------------------------------
// Bytes of utf-8 strings are pushed through the input channel. Each
// transfer is run through a cycle-free decoder model kept in this module,
// and the result it predicts is queued. A monitor pops the queue on every
// result transfer and compares it field by field. A short directed set
// covers the range extremes and the mode-specific forms. Random strings
// follow in every decode mode, under three patterns of idling on the two
// channels. Those strings are mostly well-formed with random content,
// with some noise and damaged sequences mixed in.
// ----------------------------------------------------------------------------
module utf8_validating_decoder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned BYTES_PER_MODE = 96;
  localparam logic [CFG_AW-1:0] MODE_ADDR = {REG_DECODE_MODE, 2'b00};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CFG_AW-1:0]   paddr = '0;
  logic [CFG_DW-1:0]   pwdata = '0;
  logic [CFG_DW-1:0]   prdata;
  logic                pready;

  utf8_validating_decoder_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // idling percentages for the two channels
  int unsigned send_idle_pct = 29;
  int unsigned recv_idle_pct = 49;

  // decoder model state, mirrors the per-string state of the block
  mode_t       dec_mode = MODE_STRICT;
  logic [1:0]  cont_left = '0;
  logic [1:0]  seq_len = '0;
  logic [20:0] acc = '0;
  logic [9:0]  hi_ofs = '0;
  logic        hi_held = 1'b0;
  logic        nul_wait = 1'b0;
  logic        str_broken = 1'b0;

  // predicted results in transfer order
  out_item_t expected_results[$];

  // bytes of the string being built
  logic [7:0] str_bytes[$];

  // bookkeeping
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned points_seen = 0;
  int unsigned strings_rejected = 0;

  // --------------------------------------------------------------------------
  // decoder model: one byte in, one predicted result out
  // --------------------------------------------------------------------------
  function automatic out_item_t decode_byte(in_item_t item);
    logic [7:0]  b;
    logic [20:0] got;
    logic [20:0] cp;
    logic        done;
    logic        valid;
    logic        err;
    logic        surr;
    out_item_t   res;
    b     = item.in_byte;
    got   = '0;
    cp    = '0;
    done  = 1'b0;
    valid = 1'b0;
    err   = str_broken;
    if (!str_broken) begin
      if (nul_wait) begin
        // a pending c0 only accepts 80, whatever the mode is now
        nul_wait = 1'b0;
        if (b == CONT_NUL) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end else if (cont_left != 2'd0) begin
        if (b[7:6] != 2'b10) begin
          err = 1'b1;
        end else begin
          acc = {acc[14:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          if (cont_left == 2'd0) begin
            // overlong and out-of-range forms show up on the last continuation
            if (acc > CP_MAX ||
                (seq_len == 2'd1 && acc < MIN_2BYTE) ||
                (seq_len == 2'd2 && acc < MIN_3BYTE) ||
                (seq_len == 2'd3 && acc < MIN_4BYTE)) begin
              err = 1'b1;
            end else begin
              got  = acc;
              done = 1'b1;
            end
          end
        end
      end else if (!b[7]) begin
        got  = {13'd0, b};
        done = 1'b1;
      end else if (dec_mode == MODE_CESU && b == NUL_LEAD) begin
        nul_wait = 1'b1;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
        cont_left = 2'd1;
        seq_len   = 2'd1;
        acc       = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
        cont_left = 2'd2;
        seq_len   = 2'd2;
        acc       = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
        cont_left = 2'd3;
        seq_len   = 2'd3;
        acc       = {18'd0, b[2:0]};
      end else begin
        err = 1'b1;
      end

      if (done && !err) begin
        surr = got >= SURR_HI_LO && got <= SURR_LO_HI;
        if (hi_held) begin
          // a held high half must be followed by a low half
          if (got >= SURR_LO_LO && got <= SURR_LO_HI) begin
            cp      = SUPP_BASE + {hi_ofs, 10'd0} + (got - SURR_LO_LO);
            valid   = 1'b1;
            hi_held = 1'b0;
          end else begin
            err = 1'b1;
          end
        end else if (dec_mode == MODE_STRICT && surr) begin
          err = 1'b1;
        end else if (dec_mode == MODE_CESU && surr) begin
          if (got <= SURR_HI_HI) begin
            hi_ofs  = got[9:0];
            hi_held = 1'b1;
          end else begin
            err = 1'b1;
          end
        end else begin
          cp    = got;
          valid = 1'b1;
        end
      end

      // anything unfinished on the final byte spoils the string
      if (item.in_last && (cont_left != 2'd0 || nul_wait || hi_held)) begin
        err = 1'b1;
      end
    end

    if (err) begin
      valid      = 1'b0;
      cp         = '0;
      str_broken = 1'b1;
    end

    res.code_point   = cp;
    res.point_valid  = valid;
    res.decode_error = err;
    res.out_last     = item.in_last;

    if (item.in_last) begin
      cont_left  = '0;
      seq_len    = '0;
      acc        = '0;
      hi_ofs     = '0;
      hi_held    = 1'b0;
      nul_wait   = 1'b0;
      str_broken = 1'b0;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // one byte transfer; valid is left high so back-to-back bytes need no gap
  task automatic send_byte(logic [7:0] b, logic last);
    in_item_t item;
    item.in_byte = b;
    item.in_last = last;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (last) strings_sent++;
    expected_results.insert(expected_results.size(), decode_byte(item));
  endtask

  // sends the assembled string, flagging its final byte
  task automatic send_string_bytes();
    for (int i = 0; i < str_bytes.size(); i++) begin
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
    end
  endtask

  // adds one byte at the end of the string being built
  task automatic append_byte(logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endtask

  // appends a code point in an n-byte form; forms longer than needed give overlongs
  task automatic add_cp(logic [20:0] cp, int unsigned nbytes);
    case (nbytes)
      1: append_byte({1'b0, cp[6:0]});
      2: begin
        append_byte({3'b110, cp[10:6]});
        append_byte({2'b10, cp[5:0]});
      end
      3: begin
        append_byte({4'b1110, cp[15:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
      default: begin
        append_byte({5'b11110, cp[20:18]});
        append_byte({2'b10, cp[17:12]});
        append_byte({2'b10, cp[11:6]});
        append_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // random string: mostly valid sequences, some broken ones and noise
  task automatic send_random_string();
    int unsigned kind;
    int unsigned len;
    int unsigned pos;
    logic [20:0] cp;
    str_bytes.delete();
    repeat ($urandom_range(1, 5)) begin
      kind = $urandom_range(99);
      if (kind < 22) begin
        add_cp(21'($urandom_range(0, 'h7f)), 1);
      end else if (kind < 38) begin
        add_cp(21'($urandom_range('h80, 'h7ff)), 2);
      end else if (kind < 54) begin
        add_cp(21'($urandom_range('h800, 'hffff)), 3);
      end else if (kind < 68) begin
        add_cp(21'($urandom_range('h10000, 'h10ffff)), 4);
      end else if (kind < 78) begin
        // supplementary point as a cesu-8 surrogate pair
        cp = 21'($urandom_range('h10000, 'h10ffff) - SUPP_BASE);
        add_cp(SURR_HI_LO + cp[19:10], 3);
        add_cp(SURR_LO_LO + cp[9:0], 3);
      end else if (kind < 83) begin
        // lone surrogate half
        add_cp(21'($urandom_range(SURR_HI_LO, SURR_LO_HI)), 3);
      end else if (kind < 88) begin
        // two-byte nul form
        append_byte(NUL_LEAD);
        append_byte(CONT_NUL);
      end else if (kind < 93) begin
        // overlong: value fits a shorter form
        len = $urandom_range(2, 4);
        cp  = 21'((len == 2) ? $urandom_range(0, 'h7f) :
                  (len == 3) ? $urandom_range(0, 'h7ff) : $urandom_range(0, 'hffff));
        add_cp(cp, len);
      end else if (kind < 96) begin
        // beyond the unicode range
        add_cp(21'($urandom_range('h110000, 'h1fffff)), 4);
      end else begin
        append_byte(8'($urandom));
      end
    end

    // damage a few strings: cut short, overwrite or slip in a byte
    if ($urandom_range(99) < 12) begin
      pos = $urandom_range(0, str_bytes.size() - 1);
      case ($urandom_range(2))
        0: while (str_bytes.size() > pos + 1) void'(str_bytes.pop_back());
        1: str_bytes[pos] = 8'($urandom);
        default: str_bytes.insert(pos, 8'($urandom));
      endcase
    end
    send_string_bytes();
  endtask

  // stop sending until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------

  // writes the mode register while the block is empty, then reads it back
  task automatic write_mode(mode_t m);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= CFG_DW'(m);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    dec_mode = m;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[1:0] !== m) begin
      $display("%0t mode read-back mismatch: expected %0d actual %0d",
               $realtime, m, prdata[1:0]);
      fail_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------

  // receiver stalls at the chosen rate
  always @(posedge clk) begin
    out_ready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string field, int unsigned exp_v, int unsigned act_v);
    $display("%0t %s mismatch: expected %0h actual %0h", $realtime, field, exp_v, act_v);
    fail_count++;
  endtask

  // every result transfer is checked against the oldest prediction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $realtime, out_data);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.code_point !== exp_r.code_point)
          report_mismatch("code_point", exp_r.code_point, out_data.code_point);
        if (out_data.point_valid !== exp_r.point_valid)
          report_mismatch("point_valid", exp_r.point_valid, out_data.point_valid);
        if (out_data.decode_error !== exp_r.decode_error)
          report_mismatch("decode_error", exp_r.decode_error, out_data.decode_error);
        if (out_data.out_last !== exp_r.out_last)
          report_mismatch("out_last", exp_r.out_last, out_data.out_last);
        if (exp_r.point_valid) points_seen++;
        if (exp_r.out_last && exp_r.decode_error) strings_rejected++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $realtime,
               expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // strict mode: range extremes, bad leads, a surrogate and truncation
  task automatic test_strict_extremes();
    write_mode(MODE_STRICT);
    // nul, top of ascii and the highest scalar value
    str_bytes = {8'h00, 8'h7f, LEAD4_HI, 8'h8f, 8'hbf, 8'hbf};
    send_string_bytes();
    // c1 is never a lead; the byte after it is ignored
    str_bytes = {8'hc1, 8'h80};
    send_string_bytes();
    // surrogate half is refused
    str_bytes = {8'hed, 8'ha0, 8'h80};
    send_string_bytes();
    // lead byte on the final transfer: truncated
    str_bytes = {LEAD2_LO};
    send_string_bytes();
  endtask

  // cesu mode: two-byte nul, a joined pair, and a c0 left dangling
  task automatic test_cesu_forms();
    write_mode(MODE_CESU);
    str_bytes = {NUL_LEAD, CONT_NUL, 8'hed, 8'ha0, 8'h80, 8'hed, 8'hb0, 8'h80};
    send_string_bytes();
    str_bytes = {NUL_LEAD, 8'h41};
    send_string_bytes();
  endtask

  // pass-through mode: a lone low half comes out as it is
  task automatic test_surrogate_passthrough();
    write_mode(MODE_SURR);
    str_bytes = {8'hed, 8'hb0, 8'h80};
    send_string_bytes();
  endtask

  // random strings in every mode, the spare code included
  task automatic run_random_modes();
    int unsigned start_sent;
    for (int k = 0; k < 4; k++) begin
      write_mode(mode_t'(k));
      start_sent = bytes_sent;
      while (bytes_sent - start_sent < BYTES_PER_MODE) begin
        send_random_string();
        // occasionally let the pipeline run dry mid-stream
        if ($urandom_range(39) == 0) drain_results();
      end
    end
  endtask

  // three idling patterns: receiver-heavy, sender-heavy, then none
  task automatic test_random_traffic();
    send_idle_pct = 29;
    recv_idle_pct = 49;
    run_random_modes();
    send_idle_pct = 49;
    recv_idle_pct = 29;
    run_random_modes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_modes();
  endtask

  // full stop of the sender between two bursts of strings
  task automatic test_drain_pause();
    send_idle_pct = 29;
    recv_idle_pct = 49;
    repeat (6) send_random_string();
    drain_results();
    repeat (6) send_random_string();
  endtask

  // --------------------------------------------------------------------------
  // sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_strict_extremes();
    test_cesu_forms();
    test_surrogate_passthrough();
    test_drain_pause();
    test_random_traffic();
    drain_results();

    $display("covered %0d bytes in %0d strings across all four decode modes",
             bytes_sent, strings_sent);
    $display("%0d code points decoded, %0d strings rejected, %0d failures",
             points_seen, strings_rejected, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
